>>> design/bleadp_pkg.sv
`default_nettype none
package bleadp_pkg;

  localparam int unsigned MaxPayloadDefault = 255;
  localparam int unsigned MaxPrefixDefault  = 8;

  localparam logic [7:0] TypeShortName = 8'h08;
  localparam logic [7:0] TypeFullName  = 8'h09;
  localparam logic [7:0] TypeService16 = 8'h16;

  localparam int unsigned CfgDataWidth  = 64;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned OutDataWidth  = 24;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_NAME_PREFIX   = 2'd0,
    CFG_PREFIX_LENGTH = 2'd1,
    CFG_SERVICE_UUID  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] name_prefix;
    logic [3:0]  prefix_length;
    logic [15:0] service_uuid;
  } cfg_t;

  typedef struct packed {
    logic [7:0] service_length;
    logic [7:0] service_offset;
    logic       service_found;
    logic       has_name_field;
    logic       name_match;
  } result_t;

  function automatic logic is_name_type(logic [7:0] t);
    return (t == TypeShortName) || (t == TypeFullName);
  endfunction

endpackage
`default_nettype wire

>>> design/bleadp_scan.sv
`default_nettype none
module bleadp_scan #(
  parameter int unsigned MAX_PAYLOAD = bleadp_pkg::MaxPayloadDefault,
  parameter int unsigned MAX_PREFIX  = bleadp_pkg::MaxPrefixDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [7:0]          byte_i,
  input  wire logic                last_i,
  input  wire bleadp_pkg::cfg_t    cfg_i,
  output bleadp_pkg::result_t      result_o
);

  logic [7:0] pos_q, pos_d;
  logic [8:0] fend_q, fend_d;
  logic [7:0] flen_q, flen_d;
  logic [7:0] ftype_q, ftype_d;
  logic [7:0] uuid_lo_q, uuid_lo_d;
  logic       mis_q, mis_d;
  logic       stop_q, stop_d;
  logic       matched_q, matched_d;
  logic       seen_q, seen_d;
  logic       hit_q, hit_d;
  logic [7:0] hit_off_q, hit_off_d;
  logic [7:0] hit_len_q, hit_len_d;

  logic [3:0] plen;
  logic [8:0] pos9;
  logic [7:0] idx;
  logic [7:0] didx;
  logic [7:0] want;

  assign plen = (cfg_i.prefix_length > 4'(MAX_PREFIX)) ? 4'(MAX_PREFIX) : cfg_i.prefix_length;
  assign pos9 = {1'b0, pos_q};
  assign idx  = 8'(pos9 - fend_q + {1'b0, flen_q});
  assign didx = idx - 8'd1;
  assign want = cfg_i.name_prefix[{didx[2:0], 3'b000} +: 8];

  always_comb begin
    pos_d     = pos_q;
    fend_d    = fend_q;
    flen_d    = flen_q;
    ftype_d   = ftype_q;
    uuid_lo_d = uuid_lo_q;
    mis_d     = mis_q;
    stop_d    = stop_q;
    matched_d = matched_q;
    seen_d    = seen_q;
    hit_d     = hit_q;
    hit_off_d = hit_off_q;
    hit_len_d = hit_len_q;

    if (step_i && (pos_q < 8'(MAX_PAYLOAD))) begin
      pos_d = pos_q + 8'd1;
      if (!stop_q) begin
        if (pos9 == fend_q) begin
          if (byte_i == 8'd0) begin
            stop_d = 1'b1;
          end else begin
            flen_d = byte_i;
            fend_d = pos9 + 9'd1 + {1'b0, byte_i};
            mis_d  = 1'b0;
          end
        end else begin
          if (idx == 8'd0) begin
            ftype_d = byte_i;
          end else if (bleadp_pkg::is_name_type(ftype_q)) begin
            if ((didx < {4'b0, plen}) && (byte_i != want)) mis_d = 1'b1;
          end else if (ftype_q == bleadp_pkg::TypeService16) begin
            if (idx == 8'd1) begin
              uuid_lo_d = byte_i;
            end else if (idx == 8'd2) begin
              if ({byte_i, uuid_lo_q} != cfg_i.service_uuid) mis_d = 1'b1;
            end
          end
          // field complete on this byte
          if (9'(pos9 + 9'd1) == fend_q) begin
            if (bleadp_pkg::is_name_type(ftype_d) && (flen_q >= 8'd2) && (plen != 4'd0) &&
                !matched_q) begin
              seen_d = 1'b1;
              if (((flen_q - 8'd1) >= {4'b0, plen}) && !mis_d) matched_d = 1'b1;
            end
            if ((ftype_d == bleadp_pkg::TypeService16) && (flen_q >= 8'd3) && !mis_d &&
                !hit_q) begin
              hit_d     = 1'b1;
              hit_off_d = 8'(fend_q - {1'b0, flen_q} + 9'd3);
              hit_len_d = flen_q - 8'd3;
            end
          end
        end
      end
    end

    result_o.name_match     = matched_d;
    result_o.has_name_field = seen_d;
    result_o.service_found  = hit_d;
    result_o.service_offset = hit_d ? hit_off_d : 8'd0;
    result_o.service_length = hit_d ? hit_len_d : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      fend_q    <= '0;
      flen_q    <= '0;
      ftype_q   <= '0;
      uuid_lo_q <= '0;
      mis_q     <= 1'b0;
      stop_q    <= 1'b0;
      matched_q <= 1'b0;
      seen_q    <= 1'b0;
      hit_q     <= 1'b0;
      hit_off_q <= '0;
      hit_len_q <= '0;
    end else if (step_i && last_i) begin
      pos_q     <= '0;
      fend_q    <= '0;
      flen_q    <= '0;
      ftype_q   <= '0;
      uuid_lo_q <= '0;
      mis_q     <= 1'b0;
      stop_q    <= 1'b0;
      matched_q <= 1'b0;
      seen_q    <= 1'b0;
      hit_q     <= 1'b0;
      hit_off_q <= '0;
      hit_len_q <= '0;
    end else begin
      pos_q     <= pos_d;
      fend_q    <= fend_d;
      flen_q    <= flen_d;
      ftype_q   <= ftype_d;
      uuid_lo_q <= uuid_lo_d;
      mis_q     <= mis_d;
      stop_q    <= stop_d;
      matched_q <= matched_d;
      seen_q    <= seen_d;
      hit_q     <= hit_d;
      hit_off_q <= hit_off_d;
      hit_len_q <= hit_len_d;
    end
  end

  // next length byte never lies behind the scan position
  a_fend_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!stop_q && (pos_q < 8'(MAX_PAYLOAD))) |-> (pos9 <= fend_q))
    else $error("field end behind byte position");

  a_hit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> (hit_len_q <= 8'd252))
    else $error("service length out of range");

  a_no_hit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hit_q |-> ((hit_off_q == 8'd0) && (hit_len_q == 8'd0)))
    else $error("service record without hit");

  a_match_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    matched_q |-> seen_q)
    else $error("name match without name field");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> ((pos_q == 8'd0) && !stop_q && !hit_q))
    else $error("payload state not cleared");

endmodule
`default_nettype wire

>>> design/ble_ad_structure_parser_core.sv
// ble advertising data parser
// s_axis: one payload byte per transfer in tdata, tlast marks the final byte of a payload.
// m_axis: one summary transfer per payload, issued for the byte carrying tlast.
// cfg: write enable, register index and data; writes take effect for the next byte and
//   are expected only while no payload is in flight.
// registers: 0 name prefix (first byte in bits 7..0), 1 prefix length, 2 service uuid
// path: input register, then the combinational scan step of byte compares and a 9-bit add,
//   then the result register that holds the summary of the tlast byte
// throughput: one byte per cycle while no final byte waits for the output register
// reset: clears the scan state and all valid flags, loads prefix length 1, prefix 0, uuid 0
// stall: a pending summary holds in the output register; non-final bytes keep flowing,
//   a final byte waits in the input register until the output register frees up,
//   and s_axis_tready_o drops only then
// bytes past MAX_PAYLOAD within a payload are dropped, tlast still closes the payload
`default_nettype none
module ble_ad_structure_parser_core #(
  parameter int unsigned MAX_PAYLOAD = bleadp_pkg::MaxPayloadDefault,
  parameter int unsigned MAX_PREFIX  = bleadp_pkg::MaxPrefixDefault
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  input  wire logic [7:0]                            s_axis_tdata_i,  // data_byte
  input  wire logic                                  s_axis_tlast_i,
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  // name_match, has_name_field, service_found, service_offset[7:0], service_length[7:0]
  output logic [bleadp_pkg::OutDataWidth-1:0]        m_axis_tdata_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [bleadp_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  wire logic [bleadp_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  bleadp_pkg::cfg_t    cfg_q;
  bleadp_pkg::result_t scan_res;
  bleadp_pkg::result_t out_q;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       out_valid_q;
  logic       out_free;
  logic       s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.name_prefix   <= '0;
      cfg_q.prefix_length <= 4'd1;
      cfg_q.service_uuid  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bleadp_pkg::CFG_NAME_PREFIX:   cfg_q.name_prefix   <= cfg_data_i;
        bleadp_pkg::CFG_PREFIX_LENGTH: cfg_q.prefix_length <= cfg_data_i[3:0];
        bleadp_pkg::CFG_SERVICE_UUID:  cfg_q.service_uuid  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_adv          = s1_valid_q && (!s1_last_q || out_free);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      s1_byte_q <= s_axis_tdata_i;
      s1_last_q <= s_axis_tlast_i;
    end
  end

  bleadp_scan #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .MAX_PREFIX (MAX_PREFIX)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_adv),
    .byte_i  (s1_byte_q),
    .last_i  (s1_last_q),
    .cfg_i   (cfg_q),
    .result_o(scan_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_q <= scan_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_q};

endmodule
`default_nettype wire
